// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Clocked forms with and without a reset guard; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising edge, suspended while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at each rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lfc_pkg.sv -----
// Types, constants and helper functions for the BCD length frame CRC checker.
// Used by lfc_frame_track, the top level and the checker.
`default_nettype none

package lfc_pkg;

	localparam int BYTE_LIMIT    = 250;
	localparam int LENGTH_OFFSET = 17;

	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [7:0]  LEN_HI_POS = 8'(LENGTH_OFFSET);
	localparam logic [7:0]  LEN_LO_POS = 8'(LENGTH_OFFSET + 1);
	localparam logic [7:0]  PAY_START  = 8'(LENGTH_OFFSET + 2);
	localparam logic [8:0]  LIMIT_CNT  = 9'(BYTE_LIMIT);

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_RESTART = 1'b1
	} lfc_op_t;

	typedef struct packed {
		lfc_op_t     opcode;
		logic [7:0]  rx_byte;
	} lfc_item_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [7:0]  byte_position;
		logic        in_payload;
		logic        frame_end;
		logic        crc_good;
		logic        overflow;
	} lfc_result_t;

	// Two BCD digits (raw nibbles) to a value, saturated at 99.
	function automatic logic [6:0] bcd_pair(input logic [7:0] b);
		logic [7:0] v;
		v = 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
		return (v > 8'd99) ? 7'd99 : v[6:0];
	endfunction

	// CRC-16, poly 0x1021, MSB first, one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lfc_frame_track.sv -----
// Frame state of the checker: byte counter, BCD length, running CRC.
// Computes one result per beat from the registered input; uses lfc_pkg.
`default_nettype none

module lfc_frame_track (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  lfc_pkg::lfc_item_t  item,
	output lfc_pkg::lfc_result_t result
);

	logic [7:0]  cnt_q;
	logic [6:0]  len_hi_q;
	logic [13:0] len_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;

	logic [7:0]  cnt_d;
	logic [6:0]  len_hi_d;
	logic [13:0] len_d;
	logic [15:0] crc_d;
	logic [7:0]  crc_hi_d;

	logic [14:0] end_m1;
	logic [14:0] pos_w;
	logic [8:0]  cnt_inc;
	logic        in_pay;
	logic        fend;
	logic        good;
	logic        ovf;
	logic        clear;

	always_comb begin
		cnt_d    = cnt_q;
		len_hi_d = len_hi_q;
		len_d    = len_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		in_pay   = 1'b0;
		fend     = 1'b0;
		good     = 1'b0;
		ovf      = 1'b0;
		clear    = 1'b0;
		// position of the first CRC byte; the frame ends one later
		end_m1   = {1'b0, len_q} + 15'(lfc_pkg::LENGTH_OFFSET);
		pos_w    = {7'b0, cnt_q};
		cnt_inc  = {1'b0, cnt_q} + 9'd1;

		if (item.opcode == lfc_pkg::OP_RESTART) begin
			clear = 1'b1;
		end else begin
			if (cnt_q == lfc_pkg::LEN_HI_POS) begin
				len_hi_d = lfc_pkg::bcd_pair(item.rx_byte);
			end else if (cnt_q == lfc_pkg::LEN_LO_POS) begin
				len_d = 14'(len_hi_q) * 14'd100 + 14'(lfc_pkg::bcd_pair(item.rx_byte));
			end else if (cnt_q >= lfc_pkg::PAY_START && len_q >= 14'd2) begin
				if (pos_w < end_m1) begin
					in_pay = 1'b1;
					crc_d  = lfc_pkg::crc16_byte(crc_q, item.rx_byte);
				end else if (pos_w == end_m1) begin
					crc_hi_d = item.rx_byte;
				end else if (pos_w == end_m1 + 15'd1) begin
					fend = 1'b1;
					good = ({crc_hi_q, item.rx_byte} == crc_q);
				end
			end

			if (fend) begin
				clear = 1'b1;
			end else begin
				cnt_d = cnt_inc[7:0];
				if (cnt_inc >= lfc_pkg::LIMIT_CNT) begin
					ovf   = 1'b1;
					clear = 1'b1;
				end
			end
		end

		if (clear) begin
			cnt_d    = '0;
			len_hi_d = '0;
			len_d    = '0;
			crc_d    = '0;
			crc_hi_d = '0;
		end

		if (item.opcode == lfc_pkg::OP_RESTART) begin
			result = '0;
		end else begin
			result.data_byte     = item.rx_byte;
			result.byte_position = cnt_q;
			result.in_payload    = in_pay;
			result.frame_end     = fend;
			result.crc_good      = good;
			result.overflow      = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			crc_q    <= '0;
			crc_hi_q <= '0;
		end else if (step) begin
			cnt_q    <= cnt_d;
			len_hi_q <= len_hi_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bcd_length_frame_crc_checker.sv -----
// Top level of the BCD length frame CRC checker: input register, result register.
// Instantiates lfc_frame_track; types and constants from lfc_pkg.
//
// Usage:
//   s_axis carries one received byte per beat (tdata) and an opcode in tuser:
//   0 = byte, 1 = restart (drop the partial frame, result beat is all zero).
//   m_axis returns exactly one result beat per input beat, in order.
//   Bytes 17 and 18 of a frame hold the BCD length L; the frame ends at byte
//   L+18, which is flagged by tlast together with the CRC check in tuser.
//   A frame that reaches 250 bytes without ending is dropped and flagged.
// Timing:
//   A beat passes from the input register through the CRC/counter logic
//   into the result register, where its result becomes valid.
//   Throughput is one beat per cycle while m_axis_tready is high. The frame state
//   updates as an item moves from the input register to the result register.
// Reset and stall:
//   arst_n clears the frame state and both valid flags; the data registers
//   are not reset. When m_axis_tready is low, the result holds and at most one
//   more beat is taken into the input register before s_axis_tready drops.
`default_nettype none

module bcd_length_frame_crc_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire         s_axis_tuser,   // [0] opcode
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_position
	output logic [2:0]  m_axis_tuser,   // [0] in_payload, [1] crc_good, [2] overflow
	output logic        m_axis_tlast    // frame_end
);

	logic                 valid_s1;
	lfc_pkg::lfc_item_t   item_s1;
	logic                 valid_s2;
	lfc_pkg::lfc_result_t res_s2;
	lfc_pkg::lfc_result_t res_next;
	logic                 advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.opcode  <= lfc_pkg::lfc_op_t'(s_axis_tuser);
			item_s1.rx_byte <= s_axis_tdata;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	lfc_frame_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res_next)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.byte_position, res_s2.data_byte};
	assign m_axis_tuser  = {res_s2.overflow, res_s2.crc_good, res_s2.in_payload};
	assign m_axis_tlast  = res_s2.frame_end;

endmodule

`default_nettype wire

// ----- rtl/lfc_checker.sv -----
// Port-level checks for bcd_length_frame_crc_checker, bound to the top level.
// Uses assert_macros.svh and constants from lfc_pkg.
`default_nettype none
`include "assert_macros.svh"

module lfc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata,
	input wire [2:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	`ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> !m_axis_tvalid, "result valid during reset")
	`ASSERT_CLK(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled beat changed")
	`ASSERT_CLK(a_good_needs_end, clk, arst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0], "crc_good without frame end")
	`ASSERT_CLK(a_ovf_at_limit, clk, arst_n, m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tlast && m_axis_tdata[15:8] == 8'(lfc_pkg::BYTE_LIMIT - 1), "overflow off the byte limit")

endmodule

bind bcd_length_frame_crc_checker lfc_checker u_lfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
